// ===== rtl/mrs_pkg.sv =====
// Shared constants, payload structs and codes of the running statistics block.
package mrs_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int COUNT_BITS   = 20;
	localparam int SAMPLE_BITS  = 16;

	localparam int CH_BITS   = 3;
	localparam int IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SUM_BITS  = COUNT_BITS + SAMPLE_BITS;
	localparam int SQ_BITS   = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
	localparam int ALU_BITS  = 2 * SUM_BITS;
	localparam int DIVR_BITS = 2 * COUNT_BITS;
	localparam int STEP_BITS = $clog2(ALU_BITS + 1);
	localparam int VAR_BITS  = 31;
	localparam int UVAR_BITS = 32;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REPORT = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_DROPPED = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_SINGLE  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_MUL_NS,
		ST_MUL_SS,
		ST_DIFF,
		ST_MUL_NN,
		ST_DIV_VAR,
		ST_SUB_N,
		ST_DIV_UVAR,
		ST_DIV_MEAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]                    req_type;
		logic [CH_BITS-1:0]            channel;
		logic signed [SAMPLE_BITS-1:0] sample;
	} req_t;

	typedef struct packed {
		logic [1:0]                    status;
		logic [COUNT_BITS-1:0]         sample_count;
		logic signed [SAMPLE_BITS-1:0] mean_value;
		logic [VAR_BITS-1:0]           variance_value;
		logic [UVAR_BITS-1:0]          unbiased_variance;
		logic signed [SAMPLE_BITS-1:0] minimum_value;
		logic signed [SAMPLE_BITS-1:0] maximum_value;
		logic [COUNT_BITS-1:0]         minimum_position;
		logic [COUNT_BITS-1:0]         maximum_position;
	} rsp_t;

endpackage

// ===== rtl/multichannel_running_statistics.sv =====
// Top level: per-channel running count, sum, sum of squares and extrema with reports.
// An add passes through the add step and the output step; a clear, an unused request,
// an empty report or an out-of-range channel goes straight to the output step.
// A request is taken only in the idle state. A report runs three shift-add multiplies
// (20, 36, 20 steps) and three 72-step divides on one 73-bit adder, plus the difference, n*(n-1) and output steps.
// Reset (arst_n low) clears every channel's statistics and empties the output register.
module multichannel_running_statistics (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mrs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mrs_pkg::rsp_t rsp
);
	import mrs_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// Per-channel statistics.
	logic [COUNT_BITS-1:0]         count_store    [NUM_CHANNELS];
	logic signed [SUM_BITS-1:0]    sum_store      [NUM_CHANNELS];
	logic [SQ_BITS-1:0]            square_sum_store [NUM_CHANNELS];
	logic signed [SAMPLE_BITS-1:0] min_store      [NUM_CHANNELS];
	logic signed [SAMPLE_BITS-1:0] max_store      [NUM_CHANNELS];
	logic [COUNT_BITS-1:0]         min_pos_store  [NUM_CHANNELS];
	logic [COUNT_BITS-1:0]         max_pos_store  [NUM_CHANNELS];

	state_t state_q, state_d;
	logic [STEP_BITS-1:0]          step_q;
	logic [IDX_BITS-1:0]           ch_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [COUNT_BITS-1:0]         n_q;
	logic                          s_neg_q;
	logic [SUM_BITS-1:0]           smag_q;
	logic [ALU_BITS-1:0]           acc_q, mcand_q, ns_q, diff_q, dvd_q;
	logic [SUM_BITS-1:0]           mplier_q;
	logic [DIVR_BITS-1:0]          divisor_q, rem_q;
	logic [UVAR_BITS-1:0]          quo_q;
	logic                          ovf_q;
	logic [VAR_BITS-1:0]           var_q;
	logic [UVAR_BITS-1:0]          uvar_q;
	rsp_t                          res_q, rsp_q;
	logic                          rsp_valid_q;

	// Shared adder.
	logic [ALU_BITS-1:0] alu_a, alu_b;
	logic                alu_sub;
	logic [ALU_BITS:0]   alu_sum;
	logic [ALU_BITS-1:0] acc_next;
	logic [DIVR_BITS:0]  div_r;
	logic                qbit;
	logic [DIVR_BITS-1:0] rem_next;
	logic [UVAR_BITS-1:0] quo_next;
	logic                ovf_next;
	logic                last_step;
	logic                out_free;

	// Read of the addressed channel at request time.
	logic [IDX_BITS-1:0]        in_idx;
	logic                       in_range;
	logic [COUNT_BITS-1:0]      in_count;
	logic signed [SUM_BITS-1:0] in_sum;
	logic [SUM_BITS-1:0]        in_smag;

	// Add datapath.
	logic [COUNT_BITS-1:0]          n_new;
	logic signed [2*SAMPLE_BITS-1:0] sq_prod;
	logic [SQ_BITS-1:0]             sq_ext;

	// Results formed in one step.
	rsp_t res_idle, res_add;

	// Mean from the last division.
	logic [SAMPLE_BITS-1:0] mean_mag;

	assign in_idx   = req.channel[IDX_BITS-1:0];
	assign in_range = ({1'b0, req.channel} < (CH_BITS+1)'(NUM_CHANNELS));
	assign in_count = count_store[in_idx];
	assign in_sum   = sum_store[in_idx];
	assign in_smag  = in_sum[SUM_BITS-1] ? SUM_BITS'(-in_sum) : SUM_BITS'(in_sum);

	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign n_new   = n_q + COUNT_BITS'(1);
	assign sq_prod = sample_q * sample_q;
	assign sq_ext  = {{(SQ_BITS-2*SAMPLE_BITS){1'b0}}, $unsigned(sq_prod)};

	// Restoring division step: partial remainder with the next dividend bit.
	assign div_r = {rem_q, dvd_q[ALU_BITS-1]};

	always_comb begin
		res_idle = '0;
		if ((req.req_type == REQ_ADD && !in_range) || req.req_type == REQ_REPORT)
			res_idle.status = STAT_EMPTY;
		res_add = '0;
		if (n_q == CNT_MAX) begin
			res_add.status       = STAT_DROPPED;
			res_add.sample_count = n_q;
		end else begin
			res_add.status       = STAT_OK;
			res_add.sample_count = n_new;
		end
	end

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MUL_NS, ST_MUL_SS, ST_MUL_NN: begin
				alu_a = acc_q;
				alu_b = mcand_q;
			end
			ST_DIFF: begin
				alu_a   = ns_q;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_SUB_N: begin
				alu_a   = ALU_BITS'(divisor_q);
				alu_b   = ALU_BITS'(n_q);
				alu_sub = 1'b1;
			end
			ST_DIV_VAR, ST_DIV_UVAR, ST_DIV_MEAN: begin
				alu_a   = ALU_BITS'(div_r);
				alu_b   = ALU_BITS'(divisor_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_sum  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ (ALU_BITS+1)'(alu_sub);
	assign acc_next = mplier_q[0] ? alu_sum[ALU_BITS-1:0] : acc_q;
	// No borrow out of the subtraction means the divisor fits.
	assign qbit     = alu_sum[ALU_BITS];
	assign rem_next = qbit ? alu_sum[DIVR_BITS-1:0] : div_r[DIVR_BITS-1:0];
	assign quo_next = {quo_q[UVAR_BITS-2:0], qbit};
	assign ovf_next = ovf_q | quo_q[UVAR_BITS-1];
	assign mean_mag = quo_next[SAMPLE_BITS-1:0];

	always_comb begin
		case (state_q)
			ST_MUL_NS, ST_MUL_NN: last_step = (step_q == STEP_BITS'(COUNT_BITS - 1));
			ST_MUL_SS:            last_step = (step_q == STEP_BITS'(SUM_BITS - 1));
			ST_DIV_VAR, ST_DIV_UVAR, ST_DIV_MEAN:
				last_step = (step_q == STEP_BITS'(ALU_BITS - 1));
			default:              last_step = 1'b0;
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.req_type == REQ_ADD && in_range)
						state_d = ST_ADD;
					else if (req.req_type == REQ_REPORT && in_range && in_count != '0)
						state_d = ST_MUL_NS;
					else
						state_d = ST_OUT;
				end
			end
			ST_ADD:      state_d = ST_OUT;
			ST_MUL_NS:   if (last_step) state_d = ST_MUL_SS;
			ST_MUL_SS:   if (last_step) state_d = ST_DIFF;
			ST_DIFF:     state_d = ST_MUL_NN;
			ST_MUL_NN:   if (last_step) state_d = ST_DIV_VAR;
			ST_DIV_VAR:  if (last_step) state_d = ST_SUB_N;
			ST_SUB_N:    state_d = ST_DIV_UVAR;
			ST_DIV_UVAR: if (last_step) state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: if (last_step) state_d = ST_OUT;
			ST_OUT:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				step_q <= '0;
			else if (state_q != ST_IDLE && state_q != ST_OUT)
				step_q <= step_q + STEP_BITS'(1);
		end
	end

	// Channel statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_store[i]      <= '0;
				sum_store[i]        <= '0;
				square_sum_store[i] <= '0;
				min_store[i]        <= '0;
				max_store[i]        <= '0;
				min_pos_store[i]    <= '0;
				max_pos_store[i]    <= '0;
			end
		end else if (state_q == ST_IDLE && req_valid && req.req_type == REQ_CLEAR) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_store[i]      <= '0;
				sum_store[i]        <= '0;
				square_sum_store[i] <= '0;
				min_store[i]        <= '0;
				max_store[i]        <= '0;
				min_pos_store[i]    <= '0;
				max_pos_store[i]    <= '0;
			end
		end else if (state_q == ST_ADD && n_q != CNT_MAX) begin
			count_store[ch_q]      <= n_new;
			sum_store[ch_q]        <= sum_store[ch_q] + SUM_BITS'(sample_q);
			square_sum_store[ch_q] <= square_sum_store[ch_q] + sq_ext;
			if (n_q == '0) begin
				min_store[ch_q]     <= sample_q;
				max_store[ch_q]     <= sample_q;
				min_pos_store[ch_q] <= '0;
				max_pos_store[ch_q] <= '0;
			end else if (sample_q > max_store[ch_q]) begin
				max_store[ch_q]     <= sample_q;
				max_pos_store[ch_q] <= n_q;
			end else if (sample_q < min_store[ch_q]) begin
				min_store[ch_q]     <= sample_q;
				min_pos_store[ch_q] <= n_q;
			end
		end
	end

	// Shared datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q     <= in_idx;
				sample_q <= req.sample;
				n_q      <= in_count;
				s_neg_q  <= in_sum[SUM_BITS-1];
				smag_q   <= in_smag;
				acc_q    <= '0;
				mcand_q  <= ALU_BITS'(square_sum_store[in_idx]);
				mplier_q <= SUM_BITS'(in_count);
				res_q    <= res_idle;
			end
			ST_ADD: begin
				res_q <= res_add;
			end
			ST_MUL_NS: begin
				if (last_step) begin
					ns_q     <= acc_next;
					acc_q    <= '0;
					mcand_q  <= ALU_BITS'(smag_q);
					mplier_q <= smag_q;
				end else begin
					acc_q    <= acc_next;
					mcand_q  <= {mcand_q[ALU_BITS-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_MUL_SS: begin
				acc_q    <= acc_next;
				mcand_q  <= {mcand_q[ALU_BITS-2:0], 1'b0};
				mplier_q <= mplier_q >> 1;
			end
			ST_DIFF: begin
				// A negative difference cannot occur for real data; clamp it anyway.
				diff_q   <= qbit ? alu_sum[ALU_BITS-1:0] : '0;
				acc_q    <= '0;
				mcand_q  <= ALU_BITS'(n_q);
				mplier_q <= SUM_BITS'(n_q);
			end
			ST_MUL_NN: begin
				acc_q    <= acc_next;
				mcand_q  <= {mcand_q[ALU_BITS-2:0], 1'b0};
				mplier_q <= mplier_q >> 1;
				if (last_step) begin
					divisor_q <= acc_next[DIVR_BITS-1:0];
					dvd_q     <= diff_q;
					rem_q     <= '0;
					quo_q     <= '0;
					ovf_q     <= 1'b0;
				end
			end
			ST_DIV_VAR, ST_DIV_UVAR, ST_DIV_MEAN: begin
				if (last_step && state_q == ST_DIV_UVAR) begin
					uvar_q    <= ovf_next ? {UVAR_BITS{1'b1}} : quo_next;
					divisor_q <= DIVR_BITS'(n_q);
					dvd_q     <= ALU_BITS'(smag_q);
					rem_q     <= '0;
					quo_q     <= '0;
					ovf_q     <= 1'b0;
				end else begin
					rem_q <= rem_next;
					dvd_q <= {dvd_q[ALU_BITS-2:0], 1'b0};
					quo_q <= quo_next;
					ovf_q <= ovf_next;
				end
				if (last_step && state_q == ST_DIV_VAR)
					var_q <= (ovf_next || quo_next[UVAR_BITS-1]) ? {VAR_BITS{1'b1}}
						: quo_next[VAR_BITS-1:0];
				if (last_step && state_q == ST_DIV_MEAN) begin
					res_q.status       <= (n_q == COUNT_BITS'(1)) ? STAT_SINGLE : STAT_OK;
					res_q.sample_count <= n_q;
					res_q.mean_value   <= s_neg_q ? $signed(-mean_mag) : $signed(mean_mag);
					res_q.variance_value    <= (n_q == COUNT_BITS'(1)) ? '0 : var_q;
					res_q.unbiased_variance <= (n_q == COUNT_BITS'(1)) ? '0 : uvar_q;
					res_q.minimum_value    <= min_store[ch_q];
					res_q.maximum_value    <= max_store[ch_q];
					res_q.minimum_position <= min_pos_store[ch_q];
					res_q.maximum_position <= max_pos_store[ch_q];
				end
			end
			ST_SUB_N: begin
				// n*(n-1) from n*n.
				divisor_q <= alu_sum[DIVR_BITS-1:0];
				dvd_q     <= diff_q;
				rem_q     <= '0;
				quo_q     <= '0;
				ovf_q     <= 1'b0;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free)
			rsp_q <= res_q;
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != ST_IDLE))
		else $error("accepted transaction did not start work");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_OUT))
		else $error("result appeared outside the output step");

	a_dropped_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STAT_DROPPED) |-> (rsp.sample_count == CNT_MAX))
		else $error("dropped sample reported with unsaturated count");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < STEP_BITS'(ALU_BITS))
		else $error("step counter out of range");

endmodule

// ===== dv/tb_multichannel_running_statistics.sv =====
// Self-checking testbench for the multichannel running statistics block.
module tb_multichannel_running_statistics;
	import mrs_pkg::*;

	localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS) - 1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 320;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	multichannel_running_statistics dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// Per-channel accumulator image kept alongside the block.
	longint unsigned ch_count [NUM_CHANNELS];
	longint          ch_sum   [NUM_CHANNELS];
	longint unsigned ch_sqsum [NUM_CHANNELS];
	longint          ch_min   [NUM_CHANNELS];
	longint          ch_max   [NUM_CHANNELS];
	longint unsigned ch_minpos[NUM_CHANNELS];
	longint unsigned ch_maxpos[NUM_CHANNELS];

	rsp_t expected_rsp_q[$];
	int   mismatches = 0;
	bit   send_idling = 1'b0;
	bit   recv_idling = 1'b0;
	int   holdoff_cycles = 0;
	int   quiet_cycles = 0;

	function automatic void clear_channels();
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			ch_count[c] = 0; ch_sum[c] = 0; ch_sqsum[c] = 0;
			ch_min[c] = 0; ch_max[c] = 0; ch_minpos[c] = 0; ch_maxpos[c] = 0;
		end
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t o;
		int c;
		longint v, mean;
		longint unsigned n, smag;
		logic [127:0] nsq, ssq, diff, q;
		o = '0;
		c = int'(r.channel);
		v = longint'(r.sample);
		if (r.req_type == REQ_CLEAR) begin
			clear_channels();
			return o;
		end
		if (r.req_type == REQ_NONE)
			return o;
		if (c >= NUM_CHANNELS) begin
			o.status = STAT_EMPTY;
			return o;
		end
		n = ch_count[c];
		if (r.req_type == REQ_ADD) begin
			if (n >= COUNT_FULL) begin
				o.status = STAT_DROPPED;
				o.sample_count = COUNT_BITS'(n);
				return o;
			end
			n++;
			ch_count[c] = n;
			ch_sum[c] += v;
			ch_sqsum[c] += longint'(v * v);
			if (n == 1) begin
				ch_min[c] = v; ch_max[c] = v; ch_minpos[c] = 0; ch_maxpos[c] = 0;
			end else if (v > ch_max[c]) begin
				ch_max[c] = v; ch_maxpos[c] = n - 1;
			end else if (v < ch_min[c]) begin
				ch_min[c] = v; ch_minpos[c] = n - 1;
			end
			o.sample_count = COUNT_BITS'(n);
			return o;
		end
		if (n == 0) begin
			o.status = STAT_EMPTY;
			return o;
		end
		mean = ch_sum[c] / longint'(n);
		o.status = (n == 1) ? STAT_SINGLE : STAT_OK;
		o.sample_count = COUNT_BITS'(n);
		o.mean_value = SAMPLE_BITS'(mean);
		o.minimum_value = SAMPLE_BITS'(ch_min[c]);
		o.maximum_value = SAMPLE_BITS'(ch_max[c]);
		o.minimum_position = COUNT_BITS'(ch_minpos[c]);
		o.maximum_position = COUNT_BITS'(ch_maxpos[c]);
		if (n >= 2) begin
			smag = (ch_sum[c] < 0) ? longint'(-ch_sum[c]) : ch_sum[c];
			nsq = 128'(n) * 128'(ch_sqsum[c]);
			ssq = 128'(smag) * 128'(smag);
			diff = (nsq < ssq) ? 128'd0 : nsq - ssq;
			q = diff / (128'(n) * 128'(n));
			o.variance_value = (q > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
			q = diff / (128'(n) * 128'(n - 1));
			o.unbiased_variance = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		end
		return o;
	endfunction

	// Sends one transaction; the expectation is formed at the accepting edge.
	task automatic send_item(req_t r);
		int gap;
		if (send_idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		expected_rsp_q.insert(expected_rsp_q.size(), predict_response(r));
	endtask

	task automatic send_op(req_kind_t k, int c, int s);
		req_t r;
		r.req_type = k;
		r.channel = CH_BITS'(c);
		r.sample = SAMPLE_BITS'(s);
		send_item(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (expected_rsp_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic bit field_ok(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a && mismatches < 10)
			$display("  %s: expected %0h, actual %0h", name, e, a);
		return e === a;
	endfunction

	always @(posedge clk) begin
		rsp_t e;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected transaction at %0t", $realtime);
				mismatches++;
			end else begin
				e = expected_rsp_q.pop_front();
				if (e !== rsp) begin
					if (mismatches < 10)
						$display("Mismatch at %0t:", $realtime);
					void'(field_ok("status", 32'(e.status), 32'(rsp.status)));
					void'(field_ok("sample_count", 32'(e.sample_count),
						32'(rsp.sample_count)));
					void'(field_ok("mean_value", 32'(e.mean_value), 32'(rsp.mean_value)));
					void'(field_ok("variance_value", 32'(e.variance_value),
						32'(rsp.variance_value)));
					void'(field_ok("unbiased_variance", e.unbiased_variance,
						rsp.unbiased_variance));
					void'(field_ok("minimum_value", 32'(e.minimum_value),
						32'(rsp.minimum_value)));
					void'(field_ok("maximum_value", 32'(e.maximum_value),
						32'(rsp.maximum_value)));
					void'(field_ok("minimum_position", 32'(e.minimum_position),
						32'(rsp.minimum_position)));
					void'(field_ok("maximum_position", 32'(e.maximum_position),
						32'(rsp.maximum_position)));
					mismatches++;
				end
			end
		end
	end

	// Output side: random stall bursts, plus an optional long hold-off.
	int stall_left = 0;
	always @(negedge clk) begin
		if (holdoff_cycles > 0) begin
			holdoff_cycles--;
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (recv_idling && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 7);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int pick_sample();
		case ($urandom_range(0, 9))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(0, 3) - 2;
			default: return int'($signed(16'($urandom())));
		endcase
	endfunction

	task automatic test_directed();
		send_op(REQ_REPORT, 0, 0);        // empty channel
		send_op(REQ_ADD, 0, 100);
		send_op(REQ_REPORT, 0, 0);        // single sample
		send_op(REQ_ADD, 0, 100);         // equal value does not move extrema
		send_op(REQ_ADD, 0, 32767);
		send_op(REQ_ADD, 0, -32768);
		send_op(REQ_ADD, 0, 0);
		send_op(REQ_ADD, 0, -32768);
		send_op(REQ_REPORT, 0, 0);
		send_op(REQ_ADD, 7, -1);
		send_op(REQ_ADD, 7, -3);          // negative sum gives a negative mean
		send_op(REQ_REPORT, 7, 0);
		send_op(REQ_ADD, 3, -32768);
		send_op(REQ_ADD, 3, 32767);
		send_op(REQ_REPORT, 3, 0);
		send_op(REQ_NONE, 5, 1234);
		send_op(REQ_CLEAR, 0, 0);
		send_op(REQ_REPORT, 0, 0);
		send_op(REQ_REPORT, 7, 0);
		wait_drained();
	endtask

	task automatic test_random(int items);
		int k;
		for (int i = 0; i < items; i++) begin
			send_idling = (i < items * 4 / 5);
			recv_idling = send_idling;
			k = $urandom_range(0, 99);
			if (k < 75)
				send_op(REQ_ADD, $urandom_range(0, 7), pick_sample());
			else if (k < 94)
				send_op(REQ_REPORT, $urandom_range(0, 7), pick_sample());
			else if (k < 97)
				send_op(REQ_NONE, $urandom_range(0, 7), pick_sample());
			else
				send_op(REQ_CLEAR, $urandom_range(0, 7), pick_sample());
		end
		wait_drained();
	endtask

	// The output stays blocked while transactions keep coming, so the input stalls.
	task automatic test_backpressure();
		@(negedge clk);
		holdoff_cycles = 400;
		for (int i = 0; i < 24; i++)
			send_op((i % 6 == 5) ? REQ_REPORT : REQ_ADD, i % 8, pick_sample());
		wait_drained();
	endtask

	initial begin
		clear_channels();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		send_idling = 1'b1;
		recv_idling = 1'b1;
		test_backpressure();
		test_random(2000);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
